### rtl/core/prmf_pkg.sv
// Shared types and constants of the push-relabel maximum-flow engine.
package prmf_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_ADD_RD,
    S_ADD_WR,
    S_INIT,
    S_SAT_RD,
    S_SAT_W1,
    S_SAT_W2,
    S_SAT_END,
    S_X_RD,
    S_X_CHK,
    S_Y_RD,
    S_Y_CHK,
    S_Y_W2,
    S_X_END,
    S_RES_RD,
    S_RES,
    S_EMIT
  } state_t;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_SOLVE = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [1:0] REG_SINK_NODE   = 2'd2;

  localparam int unsigned FLOW_BITS = 22;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

endpackage

### rtl/core/push_relabel_max_flow.sv
// Push-relabel maximum-flow engine with a dense capacity matrix and one shared datapath.
//
// The block keeps a MAX_NODES x MAX_NODES capacity matrix in a memory. A clear transaction
// zeroes the whole matrix with a sweep of one entry per cycle; the same sweep runs after
// reset, and the block stalls its input until it is done. An add-edge transaction is
// accepted, then reads the entry and does one saturating write. A solve transaction first
// clears flows, heights and excesses with the same sweep, then saturates the source edges,
// reading each node's source entry and writing the forward and reverse flows where the
// source edge has capacity, and then stores the source height and excess. It then runs
// sweeps over the active nodes. Every node visit reads the node; an active one then reads
// and checks each neighbor scanned, writes the reverse flow after each push, and writes
// back; all of this goes through a single read port on each memory, which sets the pace.
// A solve's one result transaction is held in an output register, so a waiting result
// does not hold up the next input. Configuration writes are taken at any time, but are
// meant to land only while idle.
module push_relabel_max_flow #(
  parameter int MAX_NODES = 64,
  parameter int CAP_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  from_node,
  input  logic [5:0]  to_node,
  input  logic [15:0] capacity,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [21:0] max_flow
);

  localparam int NB   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int NCB  = $clog2(MAX_NODES + 1);
  localparam int AB   = 2 * NB;
  localparam int FB   = CAP_BITS + 1;
  localparam int RB   = CAP_BITS + 2;
  localparam int EXB  = CAP_BITS + NB + 2;
  localparam int HB   = NB + 2;
  localparam int DEPTH = 1 << AB;
  localparam logic [CAP_BITS-1:0] CAP_MAX = '1;

  // Configuration registers.
  logic [6:0] node_count;
  logic [5:0] source_node;
  logic [5:0] sink_node;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 7'd2;
      source_node <= 6'd0;
      sink_node   <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prmf_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
        prmf_pkg::REG_SOURCE_NODE: source_node <= cfg_data[5:0];
        prmf_pkg::REG_SINK_NODE:   sink_node   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Memories: capacity and flow matrices, node heights and excesses.
  logic        [CAP_BITS-1:0] cap_mem  [DEPTH];
  logic signed [FB-1:0]       flow_mem [DEPTH];
  logic        [HB-1:0]       hgt_mem  [MAX_NODES];
  logic signed [EXB-1:0]      exc_mem  [MAX_NODES];

  logic [AB-1:0]              cap_raddr, flow_raddr;
  logic [NB-1:0]              node_raddr;
  logic [CAP_BITS-1:0]        cap_q;
  logic signed [FB-1:0]       flow_q;
  logic [HB-1:0]              hgt_q;
  logic signed [EXB-1:0]      exc_q;

  logic                       cap_we, flow_we, hgt_we, exc_we;
  logic [AB-1:0]              cap_waddr, flow_waddr;
  logic [NB-1:0]              hgt_waddr, exc_waddr;
  logic [CAP_BITS-1:0]        cap_wdata;
  logic signed [FB-1:0]       flow_wdata;
  logic [HB-1:0]              hgt_wdata;
  logic signed [EXB-1:0]      exc_wdata;

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_waddr] <= cap_wdata;
    end
    cap_q <= cap_mem[cap_raddr];
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_waddr] <= flow_wdata;
    end
    flow_q <= flow_mem[flow_raddr];
  end

  always_ff @(posedge clk) begin
    if (hgt_we) begin
      hgt_mem[hgt_waddr] <= hgt_wdata;
    end
    hgt_q <= hgt_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (exc_we) begin
      exc_mem[exc_waddr] <= exc_wdata;
    end
    exc_q <= exc_mem[node_raddr];
  end

  // Sequencer state.
  prmf_pkg::state_t state, state_next;
  logic [AB-1:0]         cnt, cnt_next;
  logic [NB-1:0]         x, x_next;
  logic [NB-1:0]         y, y_next;
  logic [NB-1:0]         s_node, s_node_next;
  logic [NB-1:0]         t_node, t_node_next;
  logic [NB-1:0]         act_last, act_last_next;
  logic [HB-1:0]         src_hgt, src_hgt_next;
  logic [NB-1:0]         add_a, add_a_next;
  logic [NB-1:0]         add_b, add_b_next;
  logic [15:0]           add_cap, add_cap_next;
  logic signed [EXB-1:0] ex, ex_next;
  logic signed [EXB-1:0] src_exc, src_exc_next;
  logic [HB-1:0]         hx, hx_next;
  logic [HB-1:0]         lowest, lowest_next;
  logic                  pushed, pushed_next;
  logic                  found, found_next;
  logic                  changed, changed_next;
  logic signed [FB-1:0]  newflow, newflow_next;
  logic [21:0]           res, res_next;
  logic                  result_valid_next;
  logic [21:0]           max_flow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prmf_pkg::S_CLR;
      cnt          <= '0;
      result_valid <= 1'b0;
      changed      <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
      changed      <= changed_next;
    end
  end

  always_ff @(posedge clk) begin
    x        <= x_next;
    y        <= y_next;
    s_node   <= s_node_next;
    t_node   <= t_node_next;
    act_last <= act_last_next;
    src_hgt  <= src_hgt_next;
    add_a    <= add_a_next;
    add_b    <= add_b_next;
    add_cap  <= add_cap_next;
    ex       <= ex_next;
    src_exc  <= src_exc_next;
    hx       <= hx_next;
    lowest   <= lowest_next;
    pushed   <= pushed_next;
    found    <= found_next;
    newflow  <= newflow_next;
    res      <= res_next;
    max_flow <= max_flow_next;
  end

  // Datapath helpers shared by the states.
  logic [NCB-1:0]        act_n;
  logic                  degenerate;
  logic [32:0]           add_sum;
  logic signed [RB-1:0]  resid;
  logic signed [EXB-1:0] resid_w, amt, exc_plus;
  logic                  admissible, hgt_match;
  logic signed [63:0]    exc_wide;

  always_comb begin
    act_n = (32'(node_count) > MAX_NODES) ? NCB'(MAX_NODES) : NCB'(node_count);
    degenerate = (act_n < NCB'(2)) || (32'(source_node) >= 32'(act_n)) ||
                 (32'(sink_node) >= 32'(act_n)) || (source_node == sink_node);
    add_sum  = 33'(cap_q) + 33'(add_cap);
    resid    = $signed({2'b00, cap_q}) - RB'(flow_q);
    resid_w  = EXB'(resid);
    amt      = (ex < resid_w) ? ex : resid_w;
    exc_plus = exc_q + amt;
    admissible = (y != x) && (resid > 0);
    hgt_match  = ({1'b0, hx} == ({1'b0, hgt_q} + 1'b1));
    exc_wide   = 64'(exc_q);
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    x_next            = x;
    y_next            = y;
    s_node_next       = s_node;
    t_node_next       = t_node;
    act_last_next     = act_last;
    src_hgt_next      = src_hgt;
    add_a_next        = add_a;
    add_b_next        = add_b;
    add_cap_next      = add_cap;
    ex_next           = ex;
    src_exc_next      = src_exc;
    hx_next           = hx;
    lowest_next       = lowest;
    pushed_next       = pushed;
    found_next        = found;
    changed_next      = changed;
    newflow_next      = newflow;
    res_next          = res;
    max_flow_next     = max_flow;
    result_valid_next = result_valid && result_stall;

    item_stall = (state != prmf_pkg::S_IDLE);

    cap_raddr  = {x, y};
    flow_raddr = {x, y};
    node_raddr = x;
    cap_we     = 1'b0;
    cap_waddr  = cnt;
    cap_wdata  = '0;
    flow_we    = 1'b0;
    flow_waddr = cnt;
    flow_wdata = '0;
    hgt_we     = 1'b0;
    hgt_waddr  = cnt[NB-1:0];
    hgt_wdata  = '0;
    exc_we     = 1'b0;
    exc_waddr  = cnt[NB-1:0];
    exc_wdata  = '0;

    case (state)
      prmf_pkg::S_IDLE: begin
        if (item_valid) begin
          case (kind)
            prmf_pkg::KIND_CLEAR: begin
              cnt_next   = '0;
              state_next = prmf_pkg::S_CLR;
            end
            prmf_pkg::KIND_ADD: begin
              add_a_next   = NB'(from_node);
              add_b_next   = NB'(to_node);
              add_cap_next = capacity;
              if ((32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES)) begin
                state_next = prmf_pkg::S_ADD_RD;
              end
            end
            prmf_pkg::KIND_SOLVE: begin
              s_node_next   = NB'(source_node);
              t_node_next   = NB'(sink_node);
              act_last_next = NB'(act_n - NCB'(1));
              src_hgt_next  = HB'(act_n);
              cnt_next      = '0;
              if (degenerate) begin
                res_next   = '0;
                state_next = prmf_pkg::S_EMIT;
              end else begin
                state_next = prmf_pkg::S_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      prmf_pkg::S_CLR: begin
        cap_we   = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = prmf_pkg::S_IDLE;
        end
      end

      prmf_pkg::S_ADD_RD: begin
        cap_raddr  = {add_a, add_b};
        state_next = prmf_pkg::S_ADD_WR;
      end

      prmf_pkg::S_ADD_WR: begin
        cap_we    = 1'b1;
        cap_waddr = {add_a, add_b};
        cap_wdata = (add_sum > 33'(CAP_MAX)) ? CAP_MAX : CAP_BITS'(add_sum);
        state_next = prmf_pkg::S_IDLE;
      end

      prmf_pkg::S_INIT: begin
        // Flows are cleared everywhere, heights and excesses on the low addresses.
        flow_we  = 1'b1;
        hgt_we   = (32'(cnt) < MAX_NODES);
        exc_we   = (32'(cnt) < MAX_NODES);
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          y_next       = '0;
          src_exc_next = '0;
          state_next   = prmf_pkg::S_SAT_RD;
        end
      end

      prmf_pkg::S_SAT_RD: begin
        cap_raddr  = {s_node, y};
        state_next = prmf_pkg::S_SAT_W1;
      end

      prmf_pkg::S_SAT_W1: begin
        if ((y != s_node) && (cap_q != '0)) begin
          flow_we      = 1'b1;
          flow_waddr   = {s_node, y};
          flow_wdata   = $signed({1'b0, cap_q});
          exc_we       = 1'b1;
          exc_waddr    = y;
          exc_wdata    = EXB'($signed({1'b0, cap_q}));
          src_exc_next = src_exc - EXB'($signed({1'b0, cap_q}));
          newflow_next = $signed({1'b0, cap_q});
          state_next   = prmf_pkg::S_SAT_W2;
        end else if (y == act_last) begin
          state_next = prmf_pkg::S_SAT_END;
        end else begin
          y_next     = y + 1'b1;
          state_next = prmf_pkg::S_SAT_RD;
        end
      end

      prmf_pkg::S_SAT_W2: begin
        flow_we    = 1'b1;
        flow_waddr = {y, s_node};
        flow_wdata = -newflow;
        if (y == act_last) begin
          state_next = prmf_pkg::S_SAT_END;
        end else begin
          y_next     = y + 1'b1;
          state_next = prmf_pkg::S_SAT_RD;
        end
      end

      prmf_pkg::S_SAT_END: begin
        exc_we       = 1'b1;
        exc_waddr    = s_node;
        exc_wdata    = src_exc;
        hgt_we       = 1'b1;
        hgt_waddr    = s_node;
        hgt_wdata    = src_hgt;
        x_next       = '0;
        changed_next = 1'b0;
        state_next   = prmf_pkg::S_X_RD;
      end

      prmf_pkg::S_X_RD: begin
        node_raddr = x;
        state_next = prmf_pkg::S_X_CHK;
      end

      prmf_pkg::S_X_CHK: begin
        if ((x == s_node) || (x == t_node) || (exc_q == '0)) begin
          if (x != act_last) begin
            x_next     = x + 1'b1;
            state_next = prmf_pkg::S_X_RD;
          end else if (changed) begin
            x_next       = '0;
            changed_next = 1'b0;
            state_next   = prmf_pkg::S_X_RD;
          end else begin
            state_next = prmf_pkg::S_RES_RD;
          end
        end else begin
          ex_next     = exc_q;
          hx_next     = hgt_q;
          y_next      = '0;
          pushed_next = 1'b0;
          found_next  = 1'b0;
          state_next  = prmf_pkg::S_Y_RD;
        end
      end

      prmf_pkg::S_Y_RD: begin
        cap_raddr  = {x, y};
        flow_raddr = {x, y};
        node_raddr = y;
        state_next = prmf_pkg::S_Y_CHK;
      end

      prmf_pkg::S_Y_CHK: begin
        // The lowest residual neighbor is tracked in the same scan; it is only
        // used when nothing was pushed, which means the scan covered every node.
        if (admissible && (!found || (hgt_q < lowest))) begin
          lowest_next = hgt_q;
        end
        if (admissible) begin
          found_next = 1'b1;
        end
        if (admissible && hgt_match) begin
          newflow_next = FB'(EXB'(flow_q) + amt);
          flow_we      = 1'b1;
          flow_waddr   = {x, y};
          flow_wdata   = FB'(EXB'(flow_q) + amt);
          exc_we       = 1'b1;
          exc_waddr    = y;
          exc_wdata    = exc_plus;
          ex_next      = ex - amt;
          pushed_next  = 1'b1;
          changed_next = 1'b1;
          state_next   = prmf_pkg::S_Y_W2;
        end else if (y == act_last) begin
          state_next = prmf_pkg::S_X_END;
        end else begin
          y_next     = y + 1'b1;
          state_next = prmf_pkg::S_Y_RD;
        end
      end

      prmf_pkg::S_Y_W2: begin
        // Flows stay antisymmetric, so the reverse entry is the negated forward one.
        flow_we    = 1'b1;
        flow_waddr = {y, x};
        flow_wdata = -newflow;
        if ((y == act_last) || (ex == '0)) begin
          state_next = prmf_pkg::S_X_END;
        end else begin
          y_next     = y + 1'b1;
          state_next = prmf_pkg::S_Y_RD;
        end
      end

      prmf_pkg::S_X_END: begin
        exc_we    = 1'b1;
        exc_waddr = x;
        exc_wdata = ex;
        hgt_waddr = x;
        hgt_wdata = lowest + 1'b1;
        hgt_we    = (ex > 0) && !pushed && found;
        if (x != act_last) begin
          changed_next = changed || hgt_we;
          x_next       = x + 1'b1;
          state_next   = prmf_pkg::S_X_RD;
        end else if (changed || hgt_we) begin
          x_next       = '0;
          changed_next = 1'b0;
          state_next   = prmf_pkg::S_X_RD;
        end else begin
          state_next = prmf_pkg::S_RES_RD;
        end
      end

      prmf_pkg::S_RES_RD: begin
        node_raddr = t_node;
        state_next = prmf_pkg::S_RES;
      end

      prmf_pkg::S_RES: begin
        if (exc_wide < 0) begin
          res_next = '0;
        end else if (exc_wide > 64'(prmf_pkg::FLOW_MAX)) begin
          res_next = prmf_pkg::FLOW_MAX;
        end else begin
          res_next = 22'(exc_wide);
        end
        state_next = prmf_pkg::S_EMIT;
      end

      prmf_pkg::S_EMIT: begin
        if (!result_valid || !result_stall) begin
          max_flow_next     = res;
          result_valid_next = 1'b1;
          state_next        = prmf_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = prmf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### dv/push_relabel_max_flow_tb.sv
// Self-checking testbench for the push-relabel maximum-flow engine.
`timescale 1ns / 1ps

module push_relabel_max_flow_tb;

  // One command transaction as it appears on the input channel.
  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  tail;
    logic [5:0]  head;
    logic [15:0] cap;
  } flow_cmd_t;

  localparam int NODES = 64;
  // A clear sweep gives no result, so the block may still be busy after the last result
  // has come back.
  localparam int QUIET_CYCLES = 4300;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  kind;
  logic [5:0]  from_node;
  logic [5:0]  to_node;
  logic [15:0] capacity;
  logic        result_valid;
  logic        result_stall;
  logic [21:0] max_flow;

  push_relabel_max_flow u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .kind(kind), .from_node(from_node),
    .to_node(to_node), .capacity(capacity), .result_valid(result_valid),
    .result_stall(result_stall), .max_flow(max_flow)
  );

  // Commands waiting to be driven, and flow values waiting to come back.
  flow_cmd_t        pending_cmds[$];
  logic [21:0]      expected_flow[$];

  // Shadow copy of the block: capacities, working arrays of a solve, and registers.
  logic [15:0]      cap_shadow[NODES*NODES];
  longint           flow_w[NODES*NODES];
  longint           excess_w[NODES];
  int unsigned      height_w[NODES];
  int unsigned      n_reg;
  int unsigned      src_reg;
  int unsigned      snk_reg;
  int unsigned      active_n;

  int               error_count;
  int               accepted_cmds;
  int               solves_seen;
  int               results_checked;
  int               cmd_total;
  int               send_idle_pct;
  int               recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Residual capacity of the directed pair a -> b during a solve.
  function automatic longint residual_cap(int unsigned a, int unsigned b);
    return longint'(cap_shadow[a*NODES+b]) - flow_w[a*NODES+b];
  endfunction

  // Runs generic push-relabel on the shadow matrix and returns the flow into the sink,
  // saturated to the width of the result field.
  function automatic logic [21:0] predict_max_flow();
    bit          changed;
    bit          pushed;
    bit          found;
    int unsigned lowest;
    longint      amt;
    longint      r;
    for (int i = 0; i < NODES*NODES; i++) flow_w[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      height_w[i] = 0;
      excess_w[i] = 0;
    end
    active_n = (n_reg > NODES) ? NODES : n_reg;
    // Degenerate setups produce zero flow without running the algorithm.
    if (active_n < 2 || src_reg >= active_n || snk_reg >= active_n || src_reg == snk_reg)
      return '0;
    height_w[src_reg] = active_n;
    // Saturate every edge leaving the source, skipping a self loop.
    for (int y = 0; y < active_n; y++) begin
      if (y != src_reg && cap_shadow[src_reg*NODES+y] != 0) begin
        flow_w[src_reg*NODES+y] = cap_shadow[src_reg*NODES+y];
        flow_w[y*NODES+src_reg] = -longint'(cap_shadow[src_reg*NODES+y]);
        excess_w[y] += cap_shadow[src_reg*NODES+y];
        excess_w[src_reg] -= cap_shadow[src_reg*NODES+y];
      end
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int x = 0; x < active_n; x++) begin
        if (x == src_reg || x == snk_reg || excess_w[x] == 0) continue;
        pushed = 1'b0;
        for (int y = 0; y < active_n && excess_w[x] > 0; y++) begin
          r = residual_cap(x, y);
          if (y != x && r > 0 && height_w[x] == height_w[y] + 1) begin
            amt = (excess_w[x] < r) ? excess_w[x] : r;
            flow_w[x*NODES+y] += amt;
            flow_w[y*NODES+x] -= amt;
            excess_w[x] -= amt;
            excess_w[y] += amt;
            pushed = 1'b1;
            changed = 1'b1;
          end
        end
        // Relabel to one above the lowest residual neighbor; with none, nothing changes.
        if (excess_w[x] > 0 && !pushed) begin
          found = 1'b0;
          lowest = 0;
          for (int y = 0; y < active_n; y++) begin
            if (y != x && residual_cap(x, y) > 0) begin
              if (!found || height_w[y] < lowest) lowest = height_w[y];
              found = 1'b1;
            end
          end
          if (found) begin
            height_w[x] = lowest + 1;
            changed = 1'b1;
          end
        end
      end
    end
    if (excess_w[snk_reg] < 0) return '0;
    if (excess_w[snk_reg] > longint'(prmf_pkg::FLOW_MAX)) return prmf_pkg::FLOW_MAX;
    return excess_w[snk_reg][21:0];
  endfunction

  // Applies one accepted command to the shadow state.
  function automatic void apply_cmd(flow_cmd_t c);
    int unsigned sum;
    case (c.kind)
      prmf_pkg::KIND_CLEAR: begin
        for (int i = 0; i < NODES*NODES; i++) cap_shadow[i] = '0;
      end
      prmf_pkg::KIND_ADD: begin
        sum = cap_shadow[c.tail*NODES+c.head] + c.cap;
        cap_shadow[c.tail*NODES+c.head] = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
      end
      prmf_pkg::KIND_SOLVE: begin
        expected_flow.push_back(predict_max_flow());
        solves_seen++;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [21:0] got,
                                 input logic [21:0] want);
    $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Idle pattern follows the progress of the run: the sender is dense and the receiver
  // slow first, then the reverse, then both sides run flat out.
  always_comb begin
    if (accepted_cmds < cmd_total / 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 88;
    end else if (accepted_cmds < 2 * cmd_total / 3) begin
      send_idle_pct = 88;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: a transaction is accepted when valid is high and stall is low at the edge.
  // The shadow model is updated at acceptance, so prediction order follows input order.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        apply_cmd('{kind, from_node, to_node, capacity});
        accepted_cmds++;
      end
      // A stalled payload is held; otherwise load the next command or idle.
      if (!item_valid || !item_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          flow_cmd_t c;
          c = pending_cmds.pop_front();
          kind       <= c.kind;
          from_node  <= c.tail;
          to_node    <= c.head;
          capacity   <= c.cap;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction, and drives the
  // random stall on the result channel.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_flow.size() == 0) begin
          report_mismatch("result transaction with no solve pending", max_flow, '0);
        end else begin
          logic [21:0] want;
          want = expected_flow.pop_front();
          if (max_flow !== want) report_mismatch("max_flow", max_flow, want);
          results_checked++;
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_cmd(input logic [1:0] k, input int a, input int b, input int c);
    pending_cmds.push_back('{k, a[5:0], b[5:0], c[15:0]});
  endtask

  // Register writes only happen with the block idle, so wait for every queued command
  // and result to drain, then let a possible clear sweep finish.
  task automatic wait_quiet();
    while (pending_cmds.size() != 0 || item_valid || expected_flow.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Presents one register write and waits for the edge that takes it; valid stays high
  // so that writes can follow back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prmf_pkg::REG_NODE_COUNT:  n_reg   = value;
      prmf_pkg::REG_SOURCE_NODE: src_reg = value[5:0];
      prmf_pkg::REG_SINK_NODE:   snk_reg = value[5:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int n, input int s, input int t);
    wait_quiet();
    @(posedge clk);
    write_reg(prmf_pkg::REG_NODE_COUNT, n[6:0]);
    // Bit 6 of the node index registers is not used; exercise it anyway.
    write_reg(prmf_pkg::REG_SOURCE_NODE, {1'($urandom_range(1)), s[5:0]});
    write_reg(prmf_pkg::REG_SINK_NODE, {1'($urandom_range(1)), t[5:0]});
    cfg_valid <= 1'b0;
  endtask

  // One random phase: mostly edge loads among the nodes in use, with solves mixed in and one at the end.
  // Large graphs get sparse edges and fewer solves to keep the sweeps short.
  task automatic random_phase(input int n, input int count);
    int span;
    int r;
    int c;
    span = (n > NODES) ? NODES : ((n < 2) ? 2 : n);
    if ($urandom_range(2) == 0) queue_cmd(prmf_pkg::KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 6 + ((span > 16) ? -3 : 1)) begin
        queue_cmd(prmf_pkg::KIND_SOLVE, $urandom_range(63), $urandom_range(63), $urandom);
      end else if (r < 8) begin
        queue_cmd(2'd3, $urandom_range(63), $urandom_range(63), $urandom);
      end else if (r < 12) begin
        // Nodes anywhere in the field range, used or not.
        queue_cmd(prmf_pkg::KIND_ADD, $urandom_range(63), $urandom_range(63), $urandom);
      end else begin
        case ($urandom_range(3))
          0: c = 16'hFFFF - $urandom_range(3);
          1: c = $urandom;
          default: c = $urandom_range(1, 200);
        endcase
        queue_cmd(prmf_pkg::KIND_ADD, $urandom_range(span - 1), $urandom_range(span - 1), c);
      end
    end
    queue_cmd(prmf_pkg::KIND_SOLVE, 0, 0, 0);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    kind         = '0;
    from_node    = '0;
    to_node      = '0;
    capacity     = '0;
    result_stall = 1'b0;
    error_count     = 0;
    accepted_cmds   = 0;
    solves_seen     = 0;
    results_checked = 0;
    cmd_total       = 1900;
    n_reg   = 2;
    src_reg = 0;
    snk_reg = 1;
    for (int i = 0; i < NODES*NODES; i++) cap_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset configuration: saturation of one entry, a zero-capacity
    // add, a self loop, the unused kind, a clear followed by a solve, and extreme nodes.
    queue_cmd(prmf_pkg::KIND_SOLVE, 0, 0, 0);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 1, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 1, 5);
    queue_cmd(prmf_pkg::KIND_ADD, 1, 0, 0);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 0, 7);
    queue_cmd(2'd3, 63, 63, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_SOLVE, 63, 63, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_CLEAR, 63, 63, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_SOLVE, 0, 0, 0);
    queue_cmd(prmf_pkg::KIND_ADD, 63, 0, 16'h8000);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 63, 1);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 1, 3);
    queue_cmd(prmf_pkg::KIND_SOLVE, 0, 0, 0);

    // A chain with a bottleneck and a back edge on four nodes.
    configure(4, 0, 3);
    queue_cmd(prmf_pkg::KIND_CLEAR, 0, 0, 0);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 1, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_ADD, 0, 2, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_ADD, 1, 2, 10);
    queue_cmd(prmf_pkg::KIND_ADD, 2, 1, 4);
    queue_cmd(prmf_pkg::KIND_ADD, 1, 3, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_ADD, 2, 3, 16'hFFFF);
    queue_cmd(prmf_pkg::KIND_SOLVE, 0, 0, 0);

    // Fixed settings cover the register extremes and every degenerate solve; random
    // settings on small graphs follow until the command budget is spent.
    configure(8, 7, 0);   random_phase(8, 40);
    configure(5, 1, 1);   random_phase(5, 30);
    configure(3, 0, 5);   random_phase(3, 30);
    configure(1, 0, 0);   random_phase(1, 30);
    configure(0, 0, 1);   random_phase(2, 30);
    configure(127, 63, 0); random_phase(64, 40);
    configure(64, 0, 63); random_phase(64, 40);
    configure(2, 1, 0);   random_phase(2, 40);
    while (cmd_total - accepted_cmds - pending_cmds.size() > 40) begin
      int n;
      n = $urandom_range(2, 9);
      configure(n, $urandom_range(n - 1), $urandom_range(n - 1));
      random_phase(n, 45);
    end

    wait_quiet();
    $display("Covered %0d commands with %0d solves; %0d flow results compared.",
             accepted_cmds, solves_seen, results_checked);
    if (error_count == 0 && expected_flow.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400_000_000;
    $display("Timeout with %0d results still pending.", expected_flow.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
